[hw/rtl/sorted_list_insert_delete_assert.svh]
// Assertion macros for the sorted list insert/delete block.
`ifndef SORTED_LIST_INSERT_DELETE_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define SLI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define SLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SLI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SLI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/sli_pkg.sv]
// Shared types and codes for the sorted list insert/delete block.
package sli_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	// Operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	// Status codes
	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_REMOVED   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// Broadcast command from the controller to every cell
	typedef struct packed {
		logic  capture;
		logic  ins_en;
		logic  del_en;
		data_t value;
	} cmd_t;

	// Compare flags a cell hands to its right neighbor
	typedef struct packed {
		logic le;
		logic lt;
	} flag_t;

endpackage

[hw/rtl/sli_cell.sv]
// One list cell: holds one entry, compares it and shifts with its neighbors.
module sli_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  sli_pkg::cmd_t  cmd,
	input  logic           occupied,
	input  sli_pkg::data_t left_data,
	input  sli_pkg::flag_t left_flag,
	input  sli_pkg::data_t right_data,
	output sli_pkg::data_t data,
	output sli_pkg::flag_t flag,
	output logic           hit
);

	sli_pkg::data_t entry_q;
	logic           le_q;
	logic           lt_q;
	logic           eq_q;

	// Compare flags, captured when a request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q <= 1'b0;
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (cmd.capture) begin
			le_q <= occupied && ($signed(entry_q) <= $signed(cmd.value));
			lt_q <= occupied && ($signed(entry_q) <  $signed(cmd.value));
			eq_q <= occupied && (entry_q == cmd.value);
		end
	end

	// Entry update: insert shifts right from the slot, delete shifts left
	always_ff @(posedge clk) begin
		if (cmd.ins_en && !le_q) begin
			entry_q <= left_flag.le ? cmd.value : left_data;
		end else if (cmd.del_en && !lt_q) begin
			entry_q <= right_data;
		end
	end

	// First equal entry sits right after the last smaller one
	assign hit     = eq_q && left_flag.lt;
	assign data    = entry_q;
	assign flag.le = le_q;
	assign flag.lt = lt_q;

endmodule

[hw/rtl/sorted_list_insert_delete.sv]
// Top level of the sorted list insert/delete block.
//
// Keeps up to CAPACITY signed 32-bit values in ascending order in a row
// of cells, one entry per cell. A request (opcode, value) is taken at a
// rising edge with start high and busy low. Opcode 0 inserts the value
// after all entries less than or equal to it; opcode 1 removes the first
// entry equal to it.
// Timing: the edge that takes the request latches the per-cell compares;
// busy is high for the next cycle, at whose end the cells at and after
// the slot shift by one place in parallel. The result (status,
// entry_count) is then shown for one cycle with done high. The path runs
// through the compare stage and the shift stage of the cell row, and no
// new request is taken while busy is high.
// The result has no back pressure: it must be taken in the done cycle.
// Reset empties the list (count to zero) at once; entry contents are not
// cleared, since only cells below the count are ever compared.
// A full store rejects an insert with status full.
`include "sorted_list_insert_delete_assert.svh"

module sorted_list_insert_delete #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [1:0]         status,
	output logic [4:0]         entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]  count_q;
	logic           pend_q;
	logic           op_q;
	sli_pkg::data_t value_q;
	logic           done_q;
	logic [1:0]     status_q;

	sli_pkg::cmd_t  cmd;
	sli_pkg::data_t cell_data [CAPACITY];
	sli_pkg::flag_t cell_flag [CAPACITY];
	logic [CAPACITY-1:0] hit;
	logic [CAPACITY-1:0] occ;
	logic           take;
	logic           full;
	logic           found;
	logic           ins_done;

	assign take  = start && !pend_q;
	assign full  = (count_q == CW'(CAPACITY));
	assign found = |hit;

	// Command broadcast to the cell row
	always_comb begin
		cmd.capture = take;
		cmd.ins_en  = pend_q && (op_q == sli_pkg::OP_INSERT) && !full;
		cmd.del_en  = pend_q && (op_q == sli_pkg::OP_DELETE) && found;
		cmd.value   = pend_q ? value_q : value;
	end

	// Cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sli_pkg::data_t ld;
		sli_pkg::flag_t lf;
		sli_pkg::data_t rd;

		assign occ[i] = (count_q > CW'(i));

		// Left of the row counts as below every value
		if (i == 0) begin : g_first
			assign ld = '0;
			assign lf = '{le: 1'b1, lt: 1'b1};
		end else begin : g_mid
			assign ld = cell_data[i-1];
			assign lf = cell_flag[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rd = '0;
		end else begin : g_inner
			assign rd = cell_data[i+1];
		end

		sli_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.occupied   (occ[i]),
			.left_data  (ld),
			.left_flag  (lf),
			.right_data (rd),
			.data       (cell_data[i]),
			.flag       (cell_flag[i]),
			.hit        (hit[i])
		);
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (take) begin
			op_q    <= opcode;
			value_q <= value;
		end
	end

	// Control, count and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
			status_q <= sli_pkg::ST_INSERTED;
		end else begin
			pend_q <= take;
			done_q <= pend_q;
			if (pend_q) begin
				if (op_q == sli_pkg::OP_INSERT) begin
					if (full) begin
						status_q <= sli_pkg::ST_FULL;
					end else begin
						status_q <= sli_pkg::ST_INSERTED;
						count_q  <= count_q + 1'b1;
					end
				end else begin
					if (found) begin
						status_q <= sli_pkg::ST_REMOVED;
						count_q  <= count_q - 1'b1;
					end else begin
						status_q <= sli_pkg::ST_NOT_FOUND;
					end
				end
			end
		end
	end

	assign busy        = pend_q;
	assign done        = done_q;
	assign status      = status_q;
	assign entry_count = 5'(count_q);

	// Checks
	assign ins_done = done_q && (status_q == sli_pkg::ST_INSERTED);

	`SLI_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`SLI_ASSERT_NEXT(a_take_done, clk, arst_n, take, !done_q && pend_q)
	`SLI_ASSERT_NEXT(a_busy_done, clk, arst_n, pend_q, done_q && !pend_q)
	`SLI_ASSERT_IMPL(a_ins_count, clk, arst_n, ins_done, count_q == CW'($past(count_q) + 1'b1))
	`SLI_ASSERT_IMPL(a_hit_single, clk, arst_n, pend_q, $onehot0(hit))

endmodule
